@@ rtl/lhn_pkg.sv @@
package lhn_pkg;

  localparam int unsigned InWidth    = 54;
  localparam int unsigned NumDigits  = 17;
  localparam int unsigned MaxDigits  = 16;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned LenWidth   = 5;
  localparam int unsigned ClassWidth = 3;

  typedef logic [InWidth-1:0]    card_t;
  typedef logic [BcdWidth-1:0]   bcd_t;
  typedef logic [LenWidth-1:0]   len_t;
  typedef logic [ClassWidth-1:0] class_t;

  localparam class_t ClassInvalid    = 3'd0;
  localparam class_t ClassFifteen34  = 3'd1;
  localparam class_t ClassSixteen5x  = 3'd2;
  localparam class_t ClassLeadFour   = 3'd3;
  localparam class_t ClassOtherValid = 3'd4;

endpackage

@@ rtl/luhn_card_number_check.sv @@
// A request is taken only while idle, and busy stays high until the result strobe, so requests never overlap.
// Each check runs the one-bit-per-cycle binary to decimal conversion of the 54-bit input,
// followed by the one-digit-per-cycle Luhn pass over the 17 BCD digits.
// The result strobe lasts one cycle; the receiver cannot stall, and a new request is taken
// in the strobe cycle. Reset is asynchronous, active low, and returns the block to idle.
module luhn_card_number_check (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  lhn_pkg::card_t         card_value_i,
  output logic                   valid_o,
  output logic                   check_ok_o,
  output lhn_pkg::class_t        brand_class_o,
  output lhn_pkg::len_t          digit_length_o
);
  import lhn_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StDigits,
    StFinish
  } state_e;

  state_e       state_q, state_d;
  logic         conv_start;
  logic         conv_done;
  bcd_t         conv_bcd;

  bcd_t         dig_q, dig_d;
  len_t         k_q, k_d;
  len_t         count_q, count_d;
  logic [3:0]   sum_q, sum_d;
  logic [3:0]   lead_q, lead_d;
  logic [3:0]   next_q, next_d;
  logic [3:0]   prev_q, prev_d;

  logic         valid_q, valid_d;
  logic         ok_q, ok_d;
  class_t       class_q, class_d;
  len_t         len_q, len_d;

  logic [3:0]   d;
  logic [4:0]   contrib;
  logic [4:0]   sum_raw;
  logic         ok_c;
  class_t       class_c;

  assign conv_start = start && (state_q == StIdle);

  lhn_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (card_value_i),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  assign d = dig_q[3:0];

  always_comb begin
    if (!k_q[0]) begin
      contrib = {1'b0, d};
    end else if (d < 4'd5) begin
      contrib = {d, 1'b0};
    end else begin
      contrib = {d, 1'b0} - 5'd9;
    end
    sum_raw = {1'b0, sum_q} + contrib;
  end

  always_comb begin
    ok_c = (sum_q == 4'd0) && (count_q <= LenWidth'(MaxDigits));
    if (!ok_c) begin
      class_c = ClassInvalid;
    end else if ((count_q == 5'd15) && (lead_q == 4'd3) &&
                 ((next_q == 4'd4) || (next_q == 4'd7))) begin
      class_c = ClassFifteen34;
    end else if ((count_q == 5'd16) && (lead_q == 4'd5) &&
                 (next_q >= 4'd1) && (next_q <= 4'd5)) begin
      class_c = ClassSixteen5x;
    end else if (((count_q == 5'd16) || (count_q == 5'd13)) && (lead_q == 4'd4)) begin
      class_c = ClassLeadFour;
    end else begin
      class_c = ClassOtherValid;
    end
  end

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    k_d     = k_q;
    count_d = count_q;
    sum_d   = sum_q;
    lead_d  = lead_q;
    next_d  = next_q;
    prev_d  = prev_q;
    valid_d = 1'b0;
    ok_d    = ok_q;
    class_d = class_q;
    len_d   = len_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StConv;
        end
      end
      StConv: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          k_d     = '0;
          count_d = '0;
          sum_d   = '0;
          lead_d  = '0;
          next_d  = '0;
          prev_d  = '0;
          state_d = StDigits;
        end
      end
      StDigits: begin
        if (sum_raw >= 5'd10) begin
          sum_d = 4'(sum_raw - 5'd10);
        end else begin
          sum_d = sum_raw[3:0];
        end
        if (d != 4'd0) begin
          count_d = k_q + 1'b1;
          lead_d  = d;
          next_d  = prev_q;
        end
        prev_d = d;
        dig_d  = {4'd0, dig_q[BcdWidth-1:4]};
        k_d    = k_q + 1'b1;
        if (k_q == LenWidth'(NumDigits - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        valid_d = 1'b1;
        ok_d    = ok_c;
        class_d = class_c;
        len_d   = count_q;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    k_q     <= k_d;
    count_q <= count_d;
    sum_q   <= sum_d;
    lead_q  <= lead_d;
    next_q  <= next_d;
    prev_q  <= prev_d;
    ok_q    <= ok_d;
    class_q <= class_d;
    len_q   <= len_d;
  end

  assign busy           = (state_q != StIdle);
  assign valid_o        = valid_q;
  assign check_ok_o     = ok_q;
  assign brand_class_o  = class_q;
  assign digit_length_o = len_q;

endmodule

@@ rtl/lhn_bcd_conv.sv @@
module lhn_bcd_conv (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lhn_pkg::card_t value_i,
  output logic          done_o,
  output lhn_pkg::bcd_t bcd_o
);
  import lhn_pkg::*;

  localparam int unsigned CntWidth = $clog2(InWidth + 1);

  card_t                bin_q, bin_d;
  bcd_t                 bcd_q, bcd_d;
  bcd_t                 bcd_adj;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 done_q, done_d;

  // Each cycle, digits of five or more get three added before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = CntWidth'(InWidth);
    end else if (cnt_q != '0) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[InWidth-1]};
      bin_d = {bin_q[InWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
